>>> rtl/core/ibmw_pkg.sv
// ibmw_pkg: opcodes, result kinds, queue entry and result types for the
// inode block map walker. Used by every file in rtl/core except ibmw_if.
package ibmw_pkg;

	typedef enum logic [1:0] {
		OP_SET_DIRECT = 2'd0,
		OP_SET_ROOT   = 2'd1,
		OP_TRANSLATE  = 2'd2,
		OP_REPLY      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_MAPPED    = 2'd0,
		KIND_FETCH     = 2'd1,
		KIND_TOO_LARGE = 2'd2,
		KIND_PROTOCOL  = 2'd3
	} kind_t;

	localparam logic [3:0] EPB_MIN   = 4'd8;
	localparam logic [3:0] EPB_MAX   = 4'd14;
	localparam logic [3:0] EPB_RESET = 4'd11;

	// classified item handed from front to back
	typedef struct packed {
		op_t         op;
		logic [3:0]  slot;
		logic [31:0] ptr;
		logic        is_direct;
		logic [3:0]  didx;
		logic        too_large;
		logic [1:0]  lvl;
		logic [30:0] rem;
	} q_entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] block_number;
		logic [13:0] word_index;
		logic [1:0]  level;
	} result_t;

endpackage

>>> rtl/core/ibmw_if.sv
// ibmw_if: handshake channel interfaces for items, results and configuration.
// Plain valid/ready channels, no dependencies.
interface ibmw_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [3:0]  slot;
	logic [31:0] pointer_value;
	logic [30:0] logical_block;

	modport source (output valid, opcode, slot, pointer_value, logical_block, input ready);
	modport sink (input valid, opcode, slot, pointer_value, logical_block, output ready);
endinterface

interface ibmw_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] block_number;
	logic [13:0] word_index;
	logic [1:0]  level;

	modport source (output valid, kind, block_number, word_index, level, input ready);
	modport sink (input valid, kind, block_number, word_index, level, output ready);
endinterface

interface ibmw_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/inode_block_map_walker.sv
// inode_block_map_walker: an accepted item is written into the queue, and the back
// registers any result; one item per cycle sustained while results.ready holds.
// The front classifies items into a two-entry queue; the back holds the map and
// walk state and registers the result. Asynchronous reset clears all pointers,
// the walk state and the queue; entries_per_block_log2 resets to 11.
// Depends on ibmw_pkg, ibmw_if, ibmw_front, ibmw_queue, ibmw_back.
module inode_block_map_walker #(
	parameter int DIRECT_SLOTS    = 12,
	parameter int INDIRECT_LEVELS = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	ibmw_cfg_if.sink   cfg,
	ibmw_in_if.sink    items,
	ibmw_out_if.source results
);
	import ibmw_pkg::*;

	logic [3:0] epb_q;
	logic [3:0] epb_eff;
	logic       push_valid;
	logic       push_ready;
	q_entry_t   push_data;
	logic       pop_valid;
	logic       pop_ready;
	q_entry_t   pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			epb_q <= EPB_RESET;
		else if (cfg.valid)
			epb_q <= cfg.data;
	end

	// out-of-range settings clamp to the nearest supported size
	assign epb_eff = (epb_q < EPB_MIN) ? EPB_MIN : ((epb_q > EPB_MAX) ? EPB_MAX : epb_q);

	ibmw_front #(
		.DIRECT_SLOTS(DIRECT_SLOTS),
		.INDIRECT_LEVELS(INDIRECT_LEVELS)
	) u_front (
		.items(items),
		.epb_log2(epb_eff),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	ibmw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	ibmw_back #(
		.DIRECT_SLOTS(DIRECT_SLOTS),
		.INDIRECT_LEVELS(INDIRECT_LEVELS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.epb_log2(epb_eff),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.entry(pop_data),
		.results(results)
	);

endmodule

>>> rtl/core/ibmw_front.sv
// ibmw_front: accepts items and classifies translates into direct, too large
// or indirect level with in-range offset. Depends on ibmw_pkg and ibmw_if.
module ibmw_front #(
	parameter int DIRECT_SLOTS    = 12,
	parameter int INDIRECT_LEVELS = 3
) (
	ibmw_in_if.sink          items,
	input  logic [3:0]       epb_log2,
	output logic             push_valid,
	input  logic             push_ready,
	output ibmw_pkg::q_entry_t push_data
);
	import ibmw_pkg::*;

	localparam int TW = 44;

	logic [TW-1:0] thr [INDIRECT_LEVELS];
	logic [30:0]   rem;
	logic [TW-1:0] rem_w;
	logic [TW-1:0] base;
	logic [TW-1:0] prev;
	logic [1:0]    lvl;
	logic          found;
	logic          is_direct;

	assign is_direct = items.logical_block < 31'(DIRECT_SLOTS);
	assign rem       = items.logical_block - 31'(DIRECT_SLOTS);
	assign rem_w     = TW'(rem);

	// cumulative capacity of levels 0..k; caps are distinct powers of two
	always_comb begin
		for (int k = 0; k < INDIRECT_LEVELS; k++) begin
			if (k == 0)
				thr[k] = TW'(1) << (6'(epb_log2) * 6'(k + 1));
			else
				thr[k] = thr[k-1] | (TW'(1) << (6'(epb_log2) * 6'(k + 1)));
		end
	end

	always_comb begin
		found = 1'b0;
		lvl   = 2'd0;
		base  = '0;
		prev  = '0;
		for (int k = 0; k < INDIRECT_LEVELS; k++) begin
			if (!found && rem_w < thr[k]) begin
				found = 1'b1;
				lvl   = 2'(k);
				base  = prev;
			end
			prev = thr[k];
		end
	end

	always_comb begin
		push_data           = '0;
		push_data.op        = op_t'(items.opcode);
		push_data.slot      = items.slot;
		push_data.ptr       = items.pointer_value;
		push_data.is_direct = is_direct;
		push_data.didx      = items.logical_block[3:0];
		push_data.too_large = !found;
		push_data.lvl       = lvl;
		push_data.rem       = 31'(rem_w - base);
	end

	assign push_valid  = items.valid;
	assign items.ready = push_ready;

endmodule

>>> rtl/core/ibmw_queue.sv
// ibmw_queue: two-entry queue of classified items between front and back.
// Depends on ibmw_pkg.
module ibmw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  ibmw_pkg::q_entry_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output ibmw_pkg::q_entry_t pop_data
);
	import ibmw_pkg::*;

	q_entry_t    mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_push_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && push) |=> (cnt_q == 2'd1 && pop_valid))
		else $error("push into empty queue lost");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q))
		else $error("queue pointers disagree with count");

endmodule

>>> rtl/core/ibmw_back.sv
// ibmw_back: holds the pointer map and walk state, carries out classified items
// and registers one result. Depends on ibmw_pkg and ibmw_if.
module ibmw_back #(
	parameter int DIRECT_SLOTS    = 12,
	parameter int INDIRECT_LEVELS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         epb_log2,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  ibmw_pkg::q_entry_t entry,
	ibmw_out_if.source         results
);
	import ibmw_pkg::*;

	localparam int DW = (DIRECT_SLOTS > 1) ? $clog2(DIRECT_SLOTS) : 1;
	localparam int LW = (INDIRECT_LEVELS > 1) ? $clog2(INDIRECT_LEVELS) : 1;

	logic [31:0] direct_q [DIRECT_SLOTS];
	logic [31:0] roots_q  [INDIRECT_LEVELS];
	logic        pend_q;
	logic [1:0]  wlvl_q;
	logic [30:0] wrem_q;
	logic        out_valid_q;
	result_t     out_q;

	logic        fire;
	logic        emit;
	logic        do_fetch;
	logic        end_walk;
	logic        wr_direct;
	logic        wr_root;
	logic [31:0] f_blk;
	logic [30:0] f_rem;
	logic [1:0]  f_lvl;
	logic [4:0]  sh;
	logic [31:0] mask;
	logic [13:0] f_idx;
	logic [30:0] f_nrem;
	result_t     res;

	assign fire      = pop_valid && (!out_valid_q || results.ready);
	assign pop_ready = !out_valid_q || results.ready;

	always_comb begin
		emit      = 1'b0;
		do_fetch  = 1'b0;
		end_walk  = 1'b0;
		wr_direct = 1'b0;
		wr_root   = 1'b0;
		f_blk     = entry.ptr;
		f_rem     = entry.rem;
		f_lvl     = entry.lvl;
		res       = '0;
		res.kind  = KIND_MAPPED;
		case (entry.op)
			OP_SET_DIRECT: begin
				wr_direct = {1'b0, entry.slot} < 5'(DIRECT_SLOTS);
			end
			OP_SET_ROOT: begin
				wr_root = {1'b0, entry.slot} < 5'(INDIRECT_LEVELS);
			end
			OP_TRANSLATE: begin
				emit = 1'b1;
				if (pend_q) begin
					res.kind = KIND_PROTOCOL;
				end else if (entry.is_direct) begin
					res.block_number = direct_q[entry.didx[DW-1:0]];
				end else if (entry.too_large) begin
					res.kind = KIND_TOO_LARGE;
				end else if (roots_q[entry.lvl[LW-1:0]] != 32'd0) begin
					do_fetch = 1'b1;
					f_blk    = roots_q[entry.lvl[LW-1:0]];
				end
			end
			OP_REPLY: begin
				emit = 1'b1;
				if (!pend_q) begin
					res.kind = KIND_PROTOCOL;
				end else if (entry.ptr == 32'd0 || wlvl_q == 2'd0) begin
					res.block_number = entry.ptr;
					end_walk         = 1'b1;
				end else begin
					do_fetch = 1'b1;
					f_rem    = wrem_q;
					f_lvl    = wlvl_q - 2'd1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// fetch split: word index above the level's shift, remainder below it
	always_comb begin
		case (f_lvl)
			2'd0:    sh = 5'd0;
			2'd1:    sh = {1'b0, epb_log2};
			default: sh = {epb_log2, 1'b0};
		endcase
	end

	assign mask   = (32'd1 << sh) - 32'd1;
	assign f_idx  = 14'(f_rem >> sh);
	assign f_nrem = f_rem & mask[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIRECT_SLOTS; i++)
				direct_q[i] <= '0;
			for (int i = 0; i < INDIRECT_LEVELS; i++)
				roots_q[i] <= '0;
			pend_q      <= 1'b0;
			wlvl_q      <= 2'd0;
			wrem_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire && emit)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
			if (fire) begin
				if (wr_direct)
					direct_q[entry.slot[DW-1:0]] <= entry.ptr;
				if (wr_root)
					roots_q[entry.slot[LW-1:0]] <= entry.ptr;
				if (do_fetch) begin
					pend_q <= 1'b1;
					wlvl_q <= f_lvl;
					wrem_q <= f_nrem;
				end else if (end_walk) begin
					pend_q <= 1'b0;
					wlvl_q <= 2'd0;
					wrem_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			if (do_fetch)
				out_q <= '{kind: KIND_FETCH, block_number: f_blk,
					word_index: f_idx, level: f_lvl};
			else
				out_q <= res;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.kind         = out_q.kind;
	assign results.block_number = out_q.block_number;
	assign results.word_index   = out_q.word_index;
	assign results.level        = out_q.level;

	a_idle_walk: assert property (@(posedge clk) disable iff (!arst_n)
		!pend_q |-> (wlvl_q == 2'd0 && wrem_q == 31'd0))
		else $error("walk state left over without a pending walk");
	a_fetch_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && do_fetch) |=> (pend_q && out_valid_q && results.kind == KIND_FETCH))
		else $error("fetch request without pending walk");
	a_fetch_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && do_fetch) |-> (32'(f_lvl) < 32'(INDIRECT_LEVELS)))
		else $error("fetch level beyond indirect levels");

endmodule
